/* rtl/sdsk_pkg.sv */
// Shared types, register codes and helper functions of the disk seek distance block.
package sdsk_pkg;

   // Widths fixed by the cylinder and distance fields.
   localparam int CYL_W  = 12;
   localparam int DIST_W = 24;
   localparam int SUM_W  = 14;
   localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

   // Scheduling policy codes; unused codes behave as FCFS.
   localparam logic [2:0] POL_FCFS   = 3'd0;
   localparam logic [2:0] POL_SCAN   = 3'd1;
   localparam logic [2:0] POL_CSCAN  = 3'd2;
   localparam logic [2:0] POL_LOOK   = 3'd3;
   localparam logic [2:0] POL_CLOOK  = 3'd4;

   // Configuration register indexes and reset values.
   localparam logic [1:0] REG_POLICY   = 2'd0;
   localparam logic [1:0] REG_SWEEP_UP = 2'd1;
   localparam logic [1:0] REG_MAX_CYL  = 2'd2;
   localparam logic [2:0]       RST_POLICY   = POL_SCAN;
   localparam logic             RST_SWEEP_UP = 1'b0;
   localparam logic [CYL_W-1:0] RST_MAX_CYL  = 12'd199;

   typedef struct packed {
      logic [CYL_W-1:0] cylinder;
      logic             last_item;
   } req_item_type;

   typedef struct packed {
      logic [DIST_W-1:0] total_distance;
      logic              range_error;
   } rsp_item_type;

   // Configuration register set, seen by both the front and the back.
   typedef struct packed {
      logic [2:0]       policy;
      logic             sweep_up;
      logic [CYL_W-1:0] max_cylinder;
   } cfg_type;

   // A classified request as it waits between the front and the back.
   typedef struct packed {
      logic [CYL_W-1:0] cylinder;
      logic             last_item;
      logic             is_head;
      logic             bad;
   } entry_type;

   // a - b, or zero when b exceeds a.
   function automatic logic [CYL_W-1:0] dif0(input logic [CYL_W-1:0] a,
                                             input logic [CYL_W-1:0] b);
      dif0 = (a > b) ? (a - b) : '0;
   endfunction

   // Zero extension of a cylinder value to the width of a policy sum.
   function automatic logic [SUM_W-1:0] ext(input logic [CYL_W-1:0] a);
      ext = {{(SUM_W-CYL_W){1'b0}}, a};
   endfunction

endpackage

/* rtl/sweep_disk_seek_distance_core.sv */
// A result is registered; a set's last item waits in the queue while the output register is stalled.
// Throughput: one request per cycle while the queue has room; the back end retires one queued item per cycle.
// The request queue holds QUEUE_DEPTH items so input and output may stall independently.
// Reset is synchronous: it empties the queue and output register, starts a new set,
// and returns the registers to policy SCAN, sweep toward cylinder zero, limit 199.
module sweep_disk_seek_distance_core #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  sdsk_pkg::req_item_type req_item,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output sdsk_pkg::rsp_item_type rsp_item,
   input  logic                   psel,
   input  logic                   penable,
   input  logic                   pwrite,
   input  logic [3:0]             paddr,
   input  logic [31:0]            pwdata,
   output logic [31:0]            prdata,
   output logic                   pready
);
   import sdsk_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic       cfg_write;
   logic       q_full;
   logic       q_push;
   entry_type  q_in;
   logic       q_pop;
   logic       q_valid;
   entry_type  q_out;

   // Register port: writes land in the access phase, reads are decoded directly.
   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite && pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (cfg_write && paddr[1:0] == 2'b00) begin
         case (paddr[3:2])
            REG_POLICY:   cfg_in.policy       = pwdata[2:0];
            REG_SWEEP_UP: cfg_in.sweep_up     = pwdata[0];
            REG_MAX_CYL:  cfg_in.max_cylinder = pwdata[CYL_W-1:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         REG_POLICY:   prdata = {29'd0, cfg_ff.policy};
         REG_SWEEP_UP: prdata = {31'd0, cfg_ff.sweep_up};
         REG_MAX_CYL:  prdata = {{(32-CYL_W){1'b0}}, cfg_ff.max_cylinder};
         default:      prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.policy       <= RST_POLICY;
         cfg_ff.sweep_up     <= RST_SWEEP_UP;
         cfg_ff.max_cylinder <= RST_MAX_CYL;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front end, queue and back end.
   sdsk_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .cfg       (cfg_ff),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_entry   (q_in)
   );

   sdsk_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_in),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_entry (q_out)
   );

   sdsk_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_entry   (q_out),
      .q_pop     (q_pop),
      .cfg       (cfg_ff),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

endmodule

/* rtl/sdsk_front.sv */
// Front end: accepts requests, marks the head item of each set and checks the range.
module sdsk_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  sdsk_pkg::req_item_type req_item,
   input  sdsk_pkg::cfg_type     cfg,
   input  logic                  q_full,
   output logic                  q_push,
   output sdsk_pkg::entry_type   q_entry
);
   import sdsk_pkg::*;

   logic expect_head_ff;
   logic expect_head_in;
   logic accept;

   // The front stalls only when the queue has no room.
   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign q_push    = accept;

   // Classify the transaction against the limit in force now.
   always_comb begin
      q_entry.cylinder  = req_item.cylinder;
      q_entry.last_item = req_item.last_item;
      q_entry.is_head   = expect_head_ff;
      q_entry.bad       = req_item.cylinder > cfg.max_cylinder;
   end

   // The item after a last item opens a new set.
   always_comb begin
      expect_head_in = expect_head_ff;
      if (accept) begin
         expect_head_in = req_item.last_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expect_head_ff <= 1'b1;
      end else begin
         expect_head_ff <= expect_head_in;
      end
   end

endmodule

/* rtl/sdsk_queue.sv */
// Short first-in first-out queue between the front and the back.
module sdsk_queue #(
   parameter int DEPTH = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  sdsk_pkg::entry_type push_entry,
   output logic                full,
   input  logic                pop,
   output logic                head_valid,
   output sdsk_pkg::entry_type head_entry
);
   import sdsk_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   entry_type       store_ff [DEPTH];
   logic [AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;

   function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
      bump = (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign full       = count_ff == CW'(DEPTH);
   assign head_valid = count_ff != '0;
   assign head_entry = store_ff[rd_ptr_ff];

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = push ? bump(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? bump(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

/* rtl/sdsk_back.sv */
// Back end: keeps the running set statistics and forms the total travel per set.
module sdsk_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_valid,
   input  sdsk_pkg::entry_type    q_entry,
   output logic                   q_pop,
   input  sdsk_pkg::cfg_type      cfg,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output sdsk_pkg::rsp_item_type rsp_item
);
   import sdsk_pkg::*;

   logic [CYL_W-1:0]  head_ff, head_in;
   logic [CYL_W-1:0]  prev_ff, prev_in;
   logic [CYL_W-1:0]  lo_ff, lo_in;
   logic [CYL_W-1:0]  hi_ff, hi_in;
   logic [CYL_W-1:0]  above_ff, above_in;
   logic              above_ok_ff, above_ok_in;
   logic [CYL_W-1:0]  below_ff, below_in;
   logic              below_ok_ff, below_ok_in;
   logic [DIST_W-1:0] fcfs_ff, fcfs_in;
   logic              err_ff, err_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_item_type      rsp_item_ff, rsp_item_in;

   logic              out_free;
   logic [CYL_W-1:0]  cyl;
   logic [CYL_W-1:0]  step;
   logic [DIST_W:0]   fcfs_sum;
   logic [SUM_W-1:0]  policy_sum;
   logic [DIST_W-1:0] total;

   // Non-last items never wait on the output side.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign q_pop     = q_valid && (!q_entry.last_item || out_free);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;
   assign cyl       = q_entry.cylinder;

   // Running statistics of the open set.
   always_comb begin
      head_in     = head_ff;
      prev_in     = prev_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      above_in    = above_ff;
      above_ok_in = above_ok_ff;
      below_in    = below_ff;
      below_ok_in = below_ok_ff;
      fcfs_in     = fcfs_ff;
      err_in      = err_ff;
      step        = (cyl > prev_ff) ? (cyl - prev_ff) : (prev_ff - cyl);
      fcfs_sum    = {1'b0, fcfs_ff} + {{(DIST_W + 1 - CYL_W){1'b0}}, step};
      if (q_pop) begin
         if (q_entry.is_head) begin
            head_in     = cyl;
            prev_in     = cyl;
            lo_in       = cyl;
            hi_in       = cyl;
            above_in    = '0;
            above_ok_in = 1'b0;
            below_in    = '0;
            below_ok_in = 1'b0;
            fcfs_in     = '0;
            err_in      = q_entry.bad;
         end else begin
            fcfs_in = fcfs_sum[DIST_W] ? DIST_MAX : fcfs_sum[DIST_W-1:0];
            prev_in = cyl;
            if (cyl < lo_ff) begin
               lo_in = cyl;
            end
            if (cyl > hi_ff) begin
               hi_in = cyl;
            end
            if (cyl >= head_ff) begin
               if (!above_ok_ff || cyl < above_ff) begin
                  above_in    = cyl;
                  above_ok_in = 1'b1;
               end
            end else begin
               if (!below_ok_ff || cyl > below_ff) begin
                  below_in    = cyl;
                  below_ok_in = 1'b1;
               end
            end
            err_in = err_ff || q_entry.bad;
         end
      end
   end

   // Total travel of the closing set, from its final statistics.
   always_comb begin
      policy_sum = '0;
      total      = fcfs_in;
      case (cfg.policy)
         POL_SCAN: begin
            if (!cfg.sweep_up) begin
               policy_sum = ext(head_in) + ext(hi_in);
            end else begin
               policy_sum = ext(dif0(cfg.max_cylinder, head_in))
                          + ext(dif0(cfg.max_cylinder, lo_in));
            end
            total = {{(DIST_W-SUM_W){1'b0}}, policy_sum};
         end
         POL_CSCAN: begin
            if (!cfg.sweep_up) begin
               policy_sum = ext(head_in) + ext(cfg.max_cylinder)
                          + (above_ok_in ? ext(dif0(cfg.max_cylinder, above_in)) : '0);
            end else begin
               policy_sum = ext(dif0(cfg.max_cylinder, head_in)) + ext(cfg.max_cylinder)
                          + (below_ok_in ? ext(below_in) : '0);
            end
            total = {{(DIST_W-SUM_W){1'b0}}, policy_sum};
         end
         POL_LOOK: begin
            if (!cfg.sweep_up) begin
               policy_sum = ext(dif0(head_in, lo_in)) + ext(dif0(hi_in, lo_in));
            end else begin
               policy_sum = ext(dif0(hi_in, head_in)) + ext(dif0(hi_in, lo_in));
            end
            total = {{(DIST_W-SUM_W){1'b0}}, policy_sum};
         end
         POL_CLOOK: begin
            if (!cfg.sweep_up) begin
               policy_sum = ext(dif0(head_in, lo_in)) + ext(dif0(hi_in, lo_in))
                          + (above_ok_in ? ext(dif0(hi_in, above_in)) : '0);
            end else begin
               policy_sum = ext(dif0(hi_in, head_in)) + ext(dif0(hi_in, lo_in))
                          + (below_ok_in ? ext(dif0(below_in, lo_in)) : '0);
            end
            total = {{(DIST_W-SUM_W){1'b0}}, policy_sum};
         end
         default: begin
            total = fcfs_in;
         end
      endcase
   end

   // Output register: loaded by a last item, cleared when the transaction is taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_item_in  = rsp_item_ff;
      if (q_pop && q_entry.last_item) begin
         rsp_valid_in               = 1'b1;
         rsp_item_in.total_distance = total;
         rsp_item_in.range_error    = err_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Set statistics and result payload.
   always_ff @(posedge clock) begin
      head_ff     <= head_in;
      prev_ff     <= prev_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      above_ff    <= above_in;
      above_ok_ff <= above_ok_in;
      below_ff    <= below_in;
      below_ok_ff <= below_ok_in;
      fcfs_ff     <= fcfs_in;
      err_ff      <= err_in;
      rsp_item_ff <= rsp_item_in;
   end

endmodule

/* sim/tb_sweep_disk_seek_distance_core.sv */
// Self-checking testbench for the disk seek distance core under all scheduling policies.
`timescale 1ns / 1ps

module tb_sweep_disk_seek_distance_core;
   import sdsk_pkg::*;

   localparam int IDLE_LIMIT   = 2000;
   localparam int SETTLE_TICKS = 12;
   localparam int TAIL_TICKS   = 10;
   localparam int TARGET_REQS  = 1600;

   typedef enum logic [1:0] {STEP_ITEM, STEP_CSR, STEP_DRAIN} step_kind_type;
   typedef enum logic [2:0] {
      BUS_IDLE   = 3'b001,
      BUS_SETUP  = 3'b010,
      BUS_ACCESS = 3'b100
   } bus_state_type;

   typedef struct {
      step_kind_type kind;
      req_item_type  item;
      logic [1:0]    reg_idx;
      logic [31:0]   value;
   } plan_step_type;

   // Clock, reset and block ports.
   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_item_type req_item = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_item_type rsp_item;
   logic         psel = 1'b0;
   logic         penable = 1'b0;
   logic         pwrite = 1'b0;
   logic [3:0]   paddr = '0;
   logic [31:0]  pwdata = '0;
   logic [31:0]  prdata;
   logic         pready;

   // Stimulus plan and expected seek totals.
   plan_step_type plan[$];
   rsp_item_type travel_q[$];
   logic [11:0]  plan_limit = RST_MAX_CYL;
   int           planned_reqs = 0;

   // Scheduler view: registers and running set state.
   cfg_type      cfg_now;
   logic         at_head;
   logic [11:0]  start_cyl, last_cyl, low_cyl, high_cyl, near_above, near_below;
   logic         has_above, has_below, out_of_range;
   int unsigned  seq_travel;

   // Driver and monitor bookkeeping.
   bus_state_type bus_state = BUS_IDLE;
   logic [1:0]   bus_idx;
   logic [31:0]  bus_val;
   int           gap_left = 0;
   int           settle = 0;
   int           hold_left = 0;
   bit           tx_calm = 1'b0;
   bit           rx_calm = 1'b0;
   int           idle_cycles = 0;

   // Run statistics.
   int           mismatch_count = 0;
   int           reqs_taken = 0;
   int           sets_closed = 0;
   int           writes_done = 0;
   int           results_seen = 0;
   int           error_sets = 0;
   int           saturated_sets = 0;
   logic [7:0]   policies_seen = '0;

   sweep_disk_seek_distance_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   // Free-running clock.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      $display("[%0t] MISMATCH: %s", $realtime, msg);
   endtask

   function automatic int unsigned clip_sub(input int unsigned a, input int unsigned b);
      return (a > b) ? a - b : 0;
   endfunction

   // Idle length for either side; calm stretches have no idling at all.
   function automatic int pick_gap(inout bit calm);
      int r;
      r = $urandom_range(0, 999);
      if (r < 15) calm = !calm;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Head travel of the closed set under the registers now in force.
   function automatic logic [23:0] travel_for_set();
      int unsigned h, m, lo, hi, t;
      h  = start_cyl;
      m  = cfg_now.max_cylinder;
      lo = low_cyl;
      hi = high_cyl;
      case (cfg_now.policy)
         POL_SCAN: begin
            if (!cfg_now.sweep_up) t = h + hi;
            else t = clip_sub(m, h) + clip_sub(m, lo);
         end
         POL_CSCAN: begin
            if (!cfg_now.sweep_up) t = h + m + (has_above ? clip_sub(m, near_above) : 0);
            else t = clip_sub(m, h) + m + (has_below ? near_below : 0);
         end
         POL_LOOK: begin
            if (!cfg_now.sweep_up) t = clip_sub(h, lo) + clip_sub(hi, lo);
            else t = clip_sub(hi, h) + clip_sub(hi, lo);
         end
         POL_CLOOK: begin
            if (!cfg_now.sweep_up)
               t = clip_sub(h, lo) + clip_sub(hi, lo)
                   + (has_above ? clip_sub(hi, near_above) : 0);
            else
               t = clip_sub(hi, h) + clip_sub(hi, lo)
                   + (has_below ? clip_sub(near_below, lo) : 0);
         end
         default: t = seq_travel;
      endcase
      return (t > DIST_MAX) ? DIST_MAX : t[23:0];
   endfunction

   // Fold one accepted request into the set state; a closing request owes a total.
   task automatic account_request(input req_item_type it);
      logic [11:0]  c;
      logic         bad;
      int unsigned  d;
      rsp_item_type r;
      c   = it.cylinder;
      bad = c > cfg_now.max_cylinder;
      reqs_taken++;
      if (at_head) begin
         start_cyl    = c;
         last_cyl     = c;
         low_cyl      = c;
         high_cyl     = c;
         near_above   = '0;
         has_above    = 1'b0;
         near_below   = '0;
         has_below    = 1'b0;
         seq_travel   = 0;
         out_of_range = bad;
         at_head      = 1'b0;
      end else begin
         d = (c > last_cyl) ? c - last_cyl : last_cyl - c;
         seq_travel = (seq_travel + d > DIST_MAX) ? DIST_MAX : seq_travel + d;
         last_cyl = c;
         if (c < low_cyl) low_cyl = c;
         if (c > high_cyl) high_cyl = c;
         if (c >= start_cyl) begin
            if (!has_above || c < near_above) begin
               near_above = c;
               has_above  = 1'b1;
            end
         end else if (!has_below || c > near_below) begin
            near_below = c;
            has_below  = 1'b1;
         end
         if (bad) out_of_range = 1'b1;
      end
      if (it.last_item) begin
         r.total_distance = travel_for_set();
         r.range_error    = out_of_range;
         travel_q.push_back(r);
         at_head = 1'b1;
         sets_closed++;
         policies_seen[cfg_now.policy] = 1'b1;
         if (out_of_range) error_sets++;
         if (r.total_distance == DIST_MAX) saturated_sets++;
      end
   endtask

   // Plan builders.
   task automatic add_item(input int cyl, input bit closes);
      plan_step_type s;
      s.kind           = STEP_ITEM;
      s.item.cylinder  = cyl[11:0];
      s.item.last_item = closes;
      s.reg_idx        = '0;
      s.value          = '0;
      plan.push_back(s);
      planned_reqs++;
   endtask

   task automatic add_csr(input logic [1:0] idx, input int val);
      plan_step_type s;
      s.kind    = STEP_CSR;
      s.item    = '0;
      s.reg_idx = idx;
      s.value   = val;
      plan.push_back(s);
      if (idx == REG_MAX_CYL) plan_limit = val[11:0];
   endtask

   task automatic add_drain();
      plan_step_type s;
      s.kind    = STEP_DRAIN;
      s.item    = '0;
      s.reg_idx = '0;
      s.value   = '0;
      plan.push_back(s);
   endtask

   task automatic add_random_config();
      int r;
      if ($urandom_range(0, 1)) add_csr(REG_POLICY, $urandom_range(0, 7));
      if ($urandom_range(0, 1)) add_csr(REG_SWEEP_UP, $urandom_range(0, 1));
      if ($urandom_range(0, 1)) begin
         r = $urandom_range(0, 9);
         if (r < 2) add_csr(REG_MAX_CYL, 4095);
         else if (r < 3) add_csr(REG_MAX_CYL, 1);
         else if (r < 5) add_csr(REG_MAX_CYL, 199);
         else if (r < 7) add_csr(REG_MAX_CYL, $urandom_range(1, 63));
         else add_csr(REG_MAX_CYL, $urandom_range(1, 4095));
      end
   endtask

   // Mostly in-range cylinders, with the disk ends and some beyond the limit.
   function automatic int pick_cylinder();
      int r;
      r = $urandom_range(0, 99);
      if (r < 4) return 0;
      if (r < 8) return plan_limit;
      if (r < 10) return 4095;
      if (r < 18) return $urandom_range(0, 4095);
      return $urandom_range(0, plan_limit);
   endfunction

   // Driver: presents planned transactions and performs register writes when idle.
   always @(posedge clock) begin
      logic next_valid;
      if (reset) begin
         req_valid <= 1'b0;
         psel      <= 1'b0;
         penable   <= 1'b0;
         pwrite    <= 1'b0;
         bus_state = BUS_IDLE;
         gap_left  = 0;
         settle    = 0;
         cfg_now.policy       = RST_POLICY;
         cfg_now.sweep_up     = RST_SWEEP_UP;
         cfg_now.max_cylinder = RST_MAX_CYL;
         at_head = 1'b1;
      end else begin
         next_valid = req_valid;
         if (req_valid && !req_stall) begin
            account_request(req_item);
            next_valid = 1'b0;
         end
         case (bus_state)
            BUS_SETUP: begin
               penable   <= 1'b1;
               bus_state = BUS_ACCESS;
            end
            BUS_ACCESS: begin
               // The register took the write at this edge.
               psel    <= 1'b0;
               penable <= 1'b0;
               pwrite  <= 1'b0;
               bus_state = BUS_IDLE;
               writes_done++;
               case (bus_idx)
                  REG_POLICY:   cfg_now.policy       = bus_val[2:0];
                  REG_SWEEP_UP: cfg_now.sweep_up     = bus_val[0];
                  REG_MAX_CYL:  cfg_now.max_cylinder = bus_val[11:0];
                  default: ;
               endcase
            end
            default: begin
               if (!next_valid) begin
                  if (gap_left > 0) begin
                     gap_left--;
                  end else if (plan.size() > 0) begin
                     if (plan[0].kind == STEP_ITEM) begin
                        req_item   <= plan[0].item;
                        next_valid = 1'b1;
                        void'(plan.pop_front());
                        gap_left = pick_gap(tx_calm);
                     end else if (travel_q.size() != 0) begin
                        settle = 0;
                     end else if (settle < SETTLE_TICKS) begin
                        // Let requests with no result drain through the core.
                        settle++;
                     end else begin
                        settle = 0;
                        if (plan[0].kind == STEP_CSR) begin
                           bus_idx = plan[0].reg_idx;
                           bus_val = plan[0].value;
                           psel    <= 1'b1;
                           pwrite  <= 1'b1;
                           penable <= 1'b0;
                           paddr   <= {plan[0].reg_idx, 2'b00};
                           pwdata  <= plan[0].value;
                           bus_state = BUS_SETUP;
                        end
                        void'(plan.pop_front());
                     end
                  end
               end
            end
         endcase
         req_valid <= next_valid;
      end
   end

   // Monitor: checks each result transaction and applies random back-pressure.
   always @(posedge clock) begin
      rsp_item_type want;
      int           n;
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (travel_q.size() == 0) begin
               report_mismatch($sformatf("unexpected result total=%0d range_error=%0b",
                                         rsp_item.total_distance, rsp_item.range_error));
            end else begin
               want = travel_q.pop_front();
               if (rsp_item.total_distance !== want.total_distance)
                  report_mismatch($sformatf("result %0d total_distance got %0d want %0d",
                                            results_seen, rsp_item.total_distance,
                                            want.total_distance));
               if (rsp_item.range_error !== want.range_error)
                  report_mismatch($sformatf("result %0d range_error got %0b want %0b",
                                            results_seen, rsp_item.range_error,
                                            want.range_error));
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            n = pick_gap(rx_calm);
            hold_left = (n > 0) ? n - 1 : 0;
            rsp_stall <= (n > 0);
         end
      end
   end

   // Watchdog on cycles with no transaction on any port.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || psel)
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timeout after %0d idle cycles, %0d results outstanding.",
                     idle_cycles, travel_q.size());
            $display("tb_sweep_disk_seek_distance_core: FAIL");
            $finish;
         end
      end
   end

   // Stimulus plan, reset and end of run.
   initial begin
      int len;
      int k;
      int r;

      // Directed: lone head item beyond the disk end, under reset registers.
      add_item(4095, 1'b1);
      // Both extremes in one set.
      add_item(0, 1'b0);
      add_item(4095, 1'b0);
      add_item(0, 1'b1);
      // Textbook request list, SCAN toward cylinder zero.
      add_item(53, 1'b0);  add_item(98, 1'b0);  add_item(183, 1'b0);
      add_item(37, 1'b0);  add_item(122, 1'b0); add_item(14, 1'b0);
      add_item(124, 1'b0); add_item(65, 1'b0);  add_item(67, 1'b1);
      // C-LOOK sweeping up over the full disk.
      add_csr(REG_POLICY, POL_CLOOK);
      add_csr(REG_SWEEP_UP, 1);
      add_csr(REG_MAX_CYL, 4095);
      add_item(2000, 1'b0);
      add_item(100, 1'b0);
      add_item(4000, 1'b1);
      // Smallest disk, with a request past its end.
      add_csr(REG_MAX_CYL, 1);
      add_item(1, 1'b0);
      add_item(0, 1'b0);
      add_item(2, 1'b1);
      // Registers change in the middle of a set.
      add_item(50, 1'b0);
      add_item(20, 1'b0);
      add_csr(REG_POLICY, POL_CSCAN);
      add_csr(REG_MAX_CYL, 30);
      add_item(60, 1'b0);
      add_item(10, 1'b1);

      // Random sets under changing registers.
      while (planned_reqs < TARGET_REQS) begin
         r = $urandom_range(0, 99);
         if (r < 12) add_random_config();
         else if (r < 15) add_drain();
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
         for (k = 0; k < len; k++) begin
            if (k == len / 2 && len > 2 && $urandom_range(0, 19) == 0) add_random_config();
            add_item(pick_cylinder(), k == len - 1);
         end
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      do @(posedge clock);
      while (plan.size() != 0 || req_valid || bus_state != BUS_IDLE || travel_q.size() != 0);
      repeat (TAIL_TICKS) @(posedge clock);

      $display("Run covered %0d requests in %0d sets, %0d register writes, %0d results.",
               reqs_taken, sets_closed, writes_done, results_seen);
      $display("Policy codes closed (bit per code) %b, %0d sets out of range, %0d saturated.",
               policies_seen, error_sets, saturated_sets);
      if (mismatch_count == 0)
         $display("tb_sweep_disk_seek_distance_core: PASS");
      else
         $display("tb_sweep_disk_seek_distance_core: FAIL");
      $finish;
   end

endmodule
